// ----- rtl/core/kgsr_pkg.sv -----
package kgsr_pkg;

  // per-cycle shift controls shared by every cell of the row
  typedef struct packed {
    logic shift_up;  // take value from lower neighbor (push)
    logic shift_dn;  // take value from upper neighbor (pop)
  } cell_ctrl_t;

  localparam int CFG_W = 5;

endpackage

// ----- rtl/core/kgsr_cell.sv -----
module kgsr_cell
  import kgsr_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  cell_ctrl_t             ctrl,
  input  logic [VALUE_WIDTH-1:0] from_lo,
  input  logic [VALUE_WIDTH-1:0] from_hi,
  output logic [VALUE_WIDTH-1:0] q
);

  logic [VALUE_WIDTH-1:0] q_r;
  logic [VALUE_WIDTH-1:0] q_nxt;

  always_comb begin
    q_nxt = q_r;
    if (ctrl.shift_up) begin
      q_nxt = from_lo;
    end else if (ctrl.shift_dn) begin
      q_nxt = from_hi;
    end
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
  end

  assign q = q_r;

endmodule

// ----- rtl/core/k_group_sequence_reverser.sv -----
// k-group sequence reverser
//
// input channel: in_elem_value / in_list_end, one list element per word,
// accepted when in_valid is high and in_stall is low. output channel:
// out_value / out_run_last / out_list_end, taken when out_valid is high and
// out_stall is low. group_size is written through cfg_wr_en / cfg_wr_data;
// the user must write it only while the block is idle (the block does not
// enforce this); 0 acts as 1, values above MAX_GROUP act as MAX_GROUP.
//
// values are held in a row of MAX_GROUP cells that shift up on every accepted
// word. a full group drains newest first from cell 0, shifting down; a short
// group at list end drains oldest first. the first result word is valid the
// cycle after the word that completes the group, then one word per cycle
// while out_stall is low. the block fills or drains, never both, so it takes
// no new word until the whole group has drained.
//
// while out_stall is high the current result word holds and in_stall stays
// high. reset clears the held count and sets group_size to 1; the cells
// themselves are not cleared.
module k_group_sequence_reverser
  import kgsr_pkg::*;
#(
  parameter int MAX_GROUP   = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [CFG_W-1:0]       cfg_wr_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_elem_value,
  input  logic                   in_list_end,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [VALUE_WIDTH-1:0] out_value,
  output logic                   out_run_last,
  output logic                   out_list_end
);

  localparam int CW   = $clog2(MAX_GROUP + 1);
  localparam int IW   = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
  localparam int CMPW = ((CW > CFG_W) ? CW : CFG_W) + 1;

  localparam logic ST_FILL  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  localparam logic [CMPW-1:0] K_MAX = CMPW'(MAX_GROUP);

  logic             state_r, state_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             rev_r, rev_nxt;     // drain newest first
  logic             lend_r, lend_nxt;   // run ends the list
  logic [CFG_W-1:0] group_size_r;

  logic [CMPW-1:0]  k_eff;
  logic [CMPW-1:0]  n_held;
  logic             in_acc;
  logic             out_acc;
  logic [IW-1:0]    fwd_idx;
  cell_ctrl_t       ctrl;

  logic [VALUE_WIDTH-1:0] cell_q [MAX_GROUP];

  // config register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      group_size_r <= CFG_W'(1);
    end else if (cfg_wr_en) begin
      group_size_r <= cfg_wr_data;
    end
  end

  // clamp group size into 1..MAX_GROUP
  always_comb begin
    if (group_size_r == '0) begin
      k_eff = CMPW'(1);
    end else if (CMPW'(group_size_r) > K_MAX) begin
      k_eff = K_MAX;
    end else begin
      k_eff = CMPW'(group_size_r);
    end
  end

  assign in_stall  = (state_r == ST_DRAIN);
  assign out_valid = (state_r == ST_DRAIN);
  assign in_acc    = in_valid && !in_stall;
  assign out_acc   = out_valid && !out_stall;
  assign n_held    = CMPW'(cnt_r) + CMPW'(1);

  // push on accept; pop toward cell 0 only on a reversed drain
  assign ctrl.shift_up = in_acc;
  assign ctrl.shift_dn = out_acc && rev_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rev_nxt   = rev_r;
    lend_nxt  = lend_r;
    case (state_r)
      ST_FILL: begin
        if (in_acc) begin
          cnt_nxt  = CW'(n_held);
          lend_nxt = in_list_end;
          if (n_held >= k_eff) begin
            // full group, or size lowered below the held count
            state_nxt = ST_DRAIN;
            rev_nxt   = 1'b1;
          end else if (in_list_end) begin
            // short tail keeps its order
            state_nxt = ST_DRAIN;
            rev_nxt   = 1'b0;
          end
        end
      end
      ST_DRAIN: begin
        if (out_acc) begin
          cnt_nxt = cnt_r - CW'(1);
          if (cnt_r == CW'(1)) begin
            state_nxt = ST_FILL;
          end
        end
      end
      default: begin
        state_nxt = ST_FILL;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_FILL;
      cnt_r   <= '0;
      rev_r   <= 1'b0;
      lend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rev_r   <= rev_nxt;
      lend_r  <= lend_nxt;
    end
  end

  // row of value cells, cell 0 holds the newest word
  for (genvar i = 0; i < MAX_GROUP; i++) begin : g_cell
    logic [VALUE_WIDTH-1:0] lo, hi;
    if (i == 0) begin : g_lo_in
      assign lo = in_elem_value;
    end else begin : g_lo_nb
      assign lo = cell_q[i-1];
    end
    if (i == MAX_GROUP - 1) begin : g_hi_end
      assign hi = '0;
    end else begin : g_hi_nb
      assign hi = cell_q[i+1];
    end
    kgsr_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .from_lo(lo),
      .from_hi(hi),
      .q      (cell_q[i])
    );
  end

  // oldest held word sits at cell cnt-1
  assign fwd_idx = IW'(cnt_r - CW'(1));

  assign out_value    = rev_r ? cell_q[0] : cell_q[fwd_idx];
  assign out_run_last = (cnt_r == CW'(1));
  assign out_list_end = out_run_last && lend_r;

  // held count never exceeds the row length
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CW'(MAX_GROUP) >= cnt_r)
    else $error("held count beyond cell row");

  // a draining run always has a word left
  a_drain_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != '0))
    else $error("drain with empty row");

  // filling never holds a full row
  a_fill_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL) |-> (cnt_r < CW'(MAX_GROUP)))
    else $error("row full while filling");

  // list end always starts a drain
  a_lend_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_list_end) |=> out_valid)
    else $error("list end did not drain");

endmodule

// ----- bench/kgsr_check_pkg.sv -----
`timescale 1ns / 1ps

package kgsr_check_pkg;

  import kgsr_pkg::*;

  localparam int VW        = 32;
  localparam int MAX_GROUP = 16;

  typedef struct {
    logic [VW-1:0] value;
    logic          run_last;
    logic          list_end;
  } reordered_word_t;

  // mirrors the reverser: holds pushed values and queues the words they release
  class group_reverse_checker;
    logic [VW-1:0]    held_vals[MAX_GROUP];
    int unsigned      held_n;
    logic [CFG_W-1:0] group_size;
    reordered_word_t  due_words[$];
    int unsigned      errors;

    function new();
      held_n     = 0;
      group_size = 1;
      errors     = 0;
    endfunction

    function void set_group_size(logic [CFG_W-1:0] k);
      group_size = k;
    endfunction

    // zero acts as one, oversize clamps to the row length
    function int unsigned group_len();
      int unsigned k;
      k = group_size;
      if (k == 0) k = 1;
      if (k > MAX_GROUP) k = MAX_GROUP;
      return k;
    endfunction

    function void note_word(logic [VW-1:0] v, logic lend);
      int unsigned k;
      int unsigned n;
      reordered_word_t w;
      k = group_len();
      if (held_n < MAX_GROUP) begin
        held_vals[held_n] = v;
        held_n++;
      end
      n = held_n;
      if (n >= k) begin
        for (int unsigned i = 0; i < n; i++) begin
          w.value    = held_vals[n - 1 - i];
          w.run_last = (i + 1 == n);
          w.list_end = (i + 1 == n) && lend;
          due_words.push_back(w);
        end
        held_n = 0;
      end else if (lend) begin
        for (int unsigned i = 0; i < n; i++) begin
          w.value    = held_vals[i];
          w.run_last = (i + 1 == n);
          w.list_end = (i + 1 == n);
          due_words.push_back(w);
        end
        held_n = 0;
      end
    endfunction

    function void check_result(logic [VW-1:0] v, logic rl, logic le);
      reordered_word_t w;
      if (due_words.size() == 0) begin
        $error("out_value: no word expected, actual %h", v);
        errors++;
        return;
      end
      w = due_words.pop_front();
      if (v !== w.value) begin
        $error("out_value: expected %h, actual %h", w.value, v);
        errors++;
      end
      if (rl !== w.run_last) begin
        $error("out_run_last: expected %b, actual %b", w.run_last, rl);
        errors++;
      end
      if (le !== w.list_end) begin
        $error("out_list_end: expected %b, actual %b", w.list_end, le);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return due_words.size();
    endfunction
  endclass

endpackage

// ----- bench/k_group_sequence_reverser_tb.sv -----
`timescale 1ns / 1ps

module k_group_sequence_reverser_tb;
  import kgsr_pkg::*;
  import kgsr_check_pkg::*;

  localparam int SETTLE      = 40;   // cycles to let a drain finish
  localparam int HOLD_CYCLES = 90;   // long receiver hold-off
  localparam int RAND_WORDS  = 210;

  logic             clk;
  logic             rst_n;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  logic             in_valid;
  logic             in_stall;
  logic [VW-1:0]    in_elem_value;
  logic             in_list_end;
  logic             out_valid;
  logic             out_stall;
  logic [VW-1:0]    out_value;
  logic             out_run_last;
  logic             out_list_end;

  // traffic shaping: quiet is shared by sender and receiver, hold_req drives the receiver
  bit quiet;      // no random idling on either side
  bit hold_req;   // ask the receiver for one long hold-off

  group_reverse_checker sb;
  int unsigned          rand_sent;

  k_group_sequence_reverser #(
    .MAX_GROUP  (MAX_GROUP),
    .VALUE_WIDTH(VW)
  ) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_elem_value(in_elem_value),
    .in_list_end  (in_list_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_value    (out_value),
    .out_run_last (out_run_last),
    .out_list_end (out_list_end)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, one long counted hold-off on request
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 22);
      end
    end
  end

  // result monitor: every taken word goes to the checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_value, out_run_last, out_list_end);
  end

  // offer one word and wait until the block takes it; valid stays high on return
  task automatic send_word(input logic [VW-1:0] v, input logic lend);
    in_valid      <= 1'b1;
    in_elem_value <= v;
    in_list_end   <= lend;
    forever begin
      @(posedge clk);
      if (!in_stall) break;
    end
    sb.note_word(v, lend);
  endtask

  // random sender gap before a word
  task automatic sender_gap();
    if (!quiet && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  // group size only changes once every due word has come out
  task automatic write_group_size(input logic [CFG_W-1:0] k);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= k;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_group_size(k);
  endtask

  // mostly random values, with the all-zero and all-one words now and then
  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      default: return $urandom;
    endcase
  endfunction

  // one list of random words; a cut list leaves words held in the block
  task automatic send_list(input int unsigned len, input bit cut);
    for (int unsigned i = 0; i < len; i++) begin
      sender_gap();
      send_word(pick_value(), !cut && (i + 1 == len));
      rand_sent++;
    end
  endtask

  initial begin
    int unsigned      waited;
    int unsigned      phase;
    logic [CFG_W-1:0] k;
    sb        = new();
    rand_sent = 0;
    phase     = 0;
    quiet     <= 1'b0;
    hold_req  <= 1'b0;
    rst_n         <= 1'b0;
    cfg_wr_en     <= 1'b0;
    cfg_wr_data   <= '0;
    in_valid      <= 1'b0;
    in_elem_value <= '0;
    in_list_end   <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // --- directed part ---

    // reset group size of one: pass-through, extreme values
    send_word('0, 1'b0);
    send_word('1, 1'b1);

    // group size zero acts as one
    write_group_size(5'd0);
    send_word(32'h8000_0001, 1'b1);

    // full group landing on list end, then a short tail in original order
    write_group_size(5'd3);
    send_word(32'h0000_0011, 1'b0);
    send_word(32'h0000_0022, 1'b0);
    send_word(32'h0000_0033, 1'b1);
    send_word(32'hAAAA_5555, 1'b0);
    send_word(32'h5555_AAAA, 1'b1);

    // oversize group size clamps to the full row
    write_group_size(5'd31);
    for (int i = 0; i < MAX_GROUP; i++)
      send_word(32'hC0DE_0000 + i, 1'b0);

    // group size lowered while words are held: all held words drain reversed
    send_word(32'h0000_00A1, 1'b0);
    send_word(32'h0000_00A2, 1'b0);
    send_word(32'h0000_00A3, 1'b0);
    write_group_size(5'd2);
    send_word(32'h0000_00A4, 1'b0);

    // --- random part ---
    while (rand_sent < RAND_WORDS) begin
      phase++;
      case (phase % 8)
        0:       k = 5'd1;
        1:       k = 5'd16;
        2:       k = 5'd0;
        3:       k = 5'd31;
        4:       k = 5'($urandom_range(17, 31));
        default: k = ($urandom_range(3) == 0) ? 5'($urandom_range(1, 16))
                                               : 5'($urandom_range(1, 6));
      endcase
      write_group_size(k);

      // one stretch with no idling on either side
      quiet <= (phase == 2);

      if (phase == 5) begin
        // pressure: receiver holds off while the sender keeps offering
        write_group_size(5'd16);
        hold_req <= 1'b1;
        send_list(40, 1'b0);
        send_list($urandom_range(1, 12), 1'b0);
        in_valid <= 1'b0;
      end else if (phase == 2) begin
        // long gap-free stretch
        send_list(48, 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_list($urandom_range(1, 20), $urandom_range(5) == 0);
        end
      end
    end
    quiet <= 1'b0;

    // flush whatever is still held
    send_word(pick_value(), 1'b1);
    in_valid <= 1'b0;

    // drain: wait for due words, bounded, then let the block settle
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE) @(posedge clk);
    if (sb.pending() != 0) begin
      $error("out_value: %0d expected words never arrived", sb.pending());
      sb.errors++;
    end

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
